// ===== hdl/glos_pkg.sv =====
package glos_pkg;

    localparam int COORD_W   = 22;
    localparam int FRAC_W    = 32;
    localparam int DIV_STEPS = 30;

    localparam logic [1:0] MODE_TILE  = 2'd0;
    localparam logic [1:0] MODE_DOOR  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [14:0] SLOPE_MAX = 15'h7fff;

    typedef struct packed {
        logic wr_tile;
        logic wr_door;
        logic load;
        logic setup;
        logic div_step;
        logic clamp;
        logic init;
        logic rd_tile;
        logic rd_door;
        logic adv;
        logic next_axis;
    } t_dp_cmd;

    typedef struct packed {
        logic same_tile;
        logic div_done;
        logic tile_block;
        logic door_needed;
        logic door_block;
        logic last;
        logic axis;
    } t_dp_sts;

endpackage

// ===== hdl/grid_line_of_sight.sv =====
// query steps per axis: setup, then where the axis is walked the 30-step divider, clamp, start point,
// then per crossed tile a tile read and check, plus a door read where the tile is a door
// writes leave busy low; one query at a time
// result strobe o_valid lasts one cycle, the receiver cannot stall
// synchronous active-low reset returns the controller to idle; map stores unset
module grid_line_of_sight
    import glos_pkg::*;
#(
    parameter int MAP_SIDE    = 64,
    parameter int DOOR_SLOTS  = 128,
    parameter int COORD_SHIFT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [5:0]         i_tile_x,
    input  logic [5:0]         i_tile_y,
    input  logic [7:0]         i_tile_value,
    input  logic               i_actor_blocks,
    input  logic [6:0]         i_door_index,
    input  logic [15:0]        i_door_open,
    input  logic [COORD_W-1:0] i_start_x,
    input  logic [COORD_W-1:0] i_start_y,
    input  logic [COORD_W-1:0] i_end_x,
    input  logic [COORD_W-1:0] i_end_y,
    input  logic               i_solid_actors,
    output logic               o_valid,
    output logic               o_line_clear
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    glos_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_mode       (i_mode),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_line_clear (o_line_clear)
    );

    glos_dp #(
        .MAP_SIDE    (MAP_SIDE),
        .DOOR_SLOTS  (DOOR_SLOTS),
        .COORD_SHIFT (COORD_SHIFT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_tile_x       (i_tile_x),
        .i_tile_y       (i_tile_y),
        .i_tile_value   (i_tile_value),
        .i_actor_blocks (i_actor_blocks),
        .i_door_index   (i_door_index),
        .i_door_open    (i_door_open),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_solid_actors (i_solid_actors),
        .o_sts          (sts)
    );

endmodule

// ===== hdl/glos_ctrl.sv =====
module glos_ctrl
    import glos_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_mode,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_valid,
    output logic       o_line_clear
);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_DIV, S_MUL, S_INIT, S_ADDR, S_TILE, S_DOOR
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_clear, n_clear;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_valid = 1'b0;
        n_clear = r_clear;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_mode)
                        MODE_TILE:  o_cmd.wr_tile = 1'b1;
                        MODE_DOOR:  o_cmd.wr_door = 1'b1;
                        MODE_QUERY: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_SETUP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (!i_sts.same_tile) begin
                    n_state = S_DIV;
                end else if (!i_sts.axis) begin
                    o_cmd.next_axis = 1'b1;
                end else begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_clear = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_INIT;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.rd_tile = 1'b1;
                n_state       = S_TILE;
            end
            S_TILE, S_DOOR: begin
                if ((r_state == S_TILE && i_sts.tile_block) ||
                    (r_state == S_DOOR && i_sts.door_block)) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_clear = 1'b0;
                end else if (r_state == S_TILE && i_sts.door_needed) begin
                    o_cmd.rd_door = 1'b1;
                    n_state       = S_DOOR;
                end else begin
                    o_cmd.adv = 1'b1;
                    if (!i_sts.last) begin
                        n_state = S_ADDR;
                    end else if (!i_sts.axis) begin
                        o_cmd.next_axis = 1'b1;
                        n_state         = S_SETUP;
                    end else begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        n_clear = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_clear <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_clear <= n_clear;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_line_clear = r_clear;

endmodule

// ===== hdl/glos_dp.sv =====
module glos_dp
    import glos_pkg::*;
#(
    parameter int MAP_SIDE    = 64,
    parameter int DOOR_SLOTS  = 128,
    parameter int COORD_SHIFT = 8
) (
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    input  logic [5:0]         i_tile_x,
    input  logic [5:0]         i_tile_y,
    input  logic [7:0]         i_tile_value,
    input  logic               i_actor_blocks,
    input  logic [6:0]         i_door_index,
    input  logic [15:0]        i_door_open,
    input  logic [COORD_W-1:0] i_start_x,
    input  logic [COORD_W-1:0] i_start_y,
    input  logic [COORD_W-1:0] i_end_x,
    input  logic [COORD_W-1:0] i_end_y,
    input  logic               i_solid_actors,
    output t_dp_sts            o_sts
);

    localparam int CW = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
    localparam int AW = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int DW = (DOOR_SLOTS > 1) ? $clog2(DOOR_SLOTS) : 1;
    localparam logic signed [23:0] SIDE_S = 24'(MAP_SIDE);

    logic [8:0]  tile_mem [MAP_SIDE*MAP_SIDE];
    logic [15:0] door_mem [DOOR_SLOTS];

    logic [COORD_W-1:0] r_x1, r_y1, r_x2, r_y2, r_b1, r_df, r_rem;
    logic               r_solid, r_axis, r_up, r_neg, r_in_map;
    logic [13:0]        r_at1, r_at2;
    logic [8:0]         r_partial;
    logic [29:0]        r_q;
    logic [4:0]         r_cnt;
    logic signed [15:0] r_slope, r_a;
    logic signed [FRAC_W-1:0] r_frac;
    logic [8:0]         r_tile_q;
    logic [15:0]        r_door_q;

    logic [COORD_W-1:0] a1, a2, b1, b2, mag;
    logic               same_tile, up;
    logic [22:0]        rem_sh;
    logic               ge;
    logic [14:0]        mag_c;
    logic signed [25:0] prod;
    logic signed [17:0] pshift;
    logic signed [23:0] bpos, apos, tx, ty;
    logic               in_map;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [7:0]         tv;
    logic               actor_hit, door_ok;
    logic signed [15:0] half;
    logic signed [FRAC_W-1:0] icpt;

    always_comb begin
        a1        = r_axis ? r_y1 : r_x1;
        a2        = r_axis ? r_y2 : r_x2;
        b1        = r_axis ? r_x1 : r_y1;
        b2        = r_axis ? r_x2 : r_y2;
        same_tile = (a1[21:8] == a2[21:8]);
        up        = (a2[21:8] > a1[21:8]);
        mag       = (b2 < b1) ? b1 - b2 : b2 - b1;
        rem_sh    = {r_rem, r_q[29]};
        ge        = (rem_sh >= {1'b0, r_df});
        mag_c     = (|r_q[29:15]) ? SLOPE_MAX : r_q[14:0];
        prod      = r_slope * $signed({1'b0, r_partial});
        pshift    = prod[25:8];
        bpos      = r_frac[31:8];
        apos      = {{8{r_a[15]}}, r_a};
        tx        = r_axis ? bpos : apos;
        ty        = r_axis ? apos : bpos;
        in_map    = (tx >= 0) && (tx < SIDE_S) && (ty >= 0) && (ty < SIDE_S);
        rd_addr   = in_map ? AW'(tx[CW-1:0] * MAP_SIDE) + AW'(ty[CW-1:0]) : '0;
        wr_addr   = AW'(CW'(i_tile_x) * MAP_SIDE) + AW'(CW'(i_tile_y));
        tv        = r_tile_q[7:0];
        actor_hit = r_solid && r_tile_q[8];
        door_ok   = (32'(tv[6:0]) < DOOR_SLOTS);
        half      = (r_slope + $signed({15'd0, r_slope[15]})) >>> 1;
        icpt      = r_frac - {{16{half[15]}}, half};
    end

    assign o_sts.same_tile   = same_tile;
    assign o_sts.div_done    = (r_cnt == 5'(DIV_STEPS - 1));
    assign o_sts.tile_block  = !r_in_map || actor_hit ||
                               (tv != 8'd0 && !tv[7]) || (tv[7] && !door_ok);
    assign o_sts.door_needed = tv[7] && door_ok;
    assign o_sts.door_block  = icpt[FRAC_W-1] ||
                               (icpt > $signed({16'd0, r_door_q}));
    assign o_sts.last        = (r_a == $signed({2'b0, r_at2}));
    assign o_sts.axis        = r_axis;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_tile && i_tile_x < MAP_SIDE && i_tile_y < MAP_SIDE) begin
            tile_mem[wr_addr] <= {i_actor_blocks, i_tile_value};
        end
        if (i_cmd.rd_tile) begin
            r_tile_q <= tile_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_door && i_door_index < DOOR_SLOTS) begin
            door_mem[DW'(i_door_index)] <= i_door_open;
        end
        if (i_cmd.rd_door) begin
            r_door_q <= door_mem[DW'(tv[6:0])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x1    <= COORD_W'(i_start_x >> COORD_SHIFT);
            r_y1    <= COORD_W'(i_start_y >> COORD_SHIFT);
            r_x2    <= COORD_W'(i_end_x >> COORD_SHIFT);
            r_y2    <= COORD_W'(i_end_y >> COORD_SHIFT);
            r_solid <= i_solid_actors;
            r_axis  <= 1'b0;
        end
        if (i_cmd.next_axis) begin
            r_axis <= 1'b1;
        end
        if (i_cmd.setup) begin
            r_at1     <= a1[21:8];
            r_at2     <= a2[21:8];
            r_up      <= up;
            r_partial <= up ? 9'd256 - {1'b0, a1[7:0]} : {1'b0, a1[7:0]};
            r_df      <= up ? a2 - a1 : a1 - a2;
            r_neg     <= (b2 < b1);
            r_b1      <= b1;
            r_q       <= {mag, 8'd0};
            r_rem     <= '0;
            r_cnt     <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? COORD_W'(rem_sh - {1'b0, r_df}) : rem_sh[21:0];
            r_q   <= {r_q[28:0], ge};
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_cmd.clamp) begin
            r_slope <= r_neg ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
        end
        if (i_cmd.init) begin
            r_frac <= $signed({10'd0, r_b1}) + {{14{pshift[17]}}, pshift};
            r_a    <= r_up ? $signed({2'b0, r_at1}) + 16'sd1
                           : $signed({2'b0, r_at1}) - 16'sd1;
        end
        if (i_cmd.rd_tile) begin
            r_in_map <= in_map;
            r_frac   <= r_frac + {{16{r_slope[15]}}, r_slope};
        end
        if (i_cmd.adv) begin
            r_a <= r_up ? r_a + 16'sd1 : r_a - 16'sd1;
        end
    end

endmodule

// ===== hdl/glos_checker.sv =====
module glos_checker
    import glos_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_mode,
    input logic       o_valid
);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_QUERY) |=> busy)
        else $error("query not taken");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode != MODE_QUERY) |=> (!busy && !o_valid))
        else $error("write item held the block");

    a_result_ends_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy)) else $error("stray result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid)) else $error("reset not idle");

endmodule

bind grid_line_of_sight glos_checker u_chk (.*);
